@@ rtl/core/stack_queue_engine_unit_assert.svh @@
// Assertion macros used by the stack and queue engine RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef STACK_QUEUE_ENGINE_UNIT_ASSERT_SVH
`define STACK_QUEUE_ENGINE_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define SQE_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

// The consequence holds in the same cycle as the antecedent.
`define SQE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// The consequence holds in the cycle after the antecedent.
`define SQE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

@@ rtl/core/sqe_pkg.sv @@
// Types and constants of the stack and queue engine.
// Depends on nothing; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package sqe_pkg;

   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 3'd0,
      CMD_POP  = 3'd1,
      CMD_SWAP = 3'd2,
      CMD_PEEK = 3'd3,
      CMD_DUMP = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_SHORT = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT,
      CELL_TAKE_FRONT,
      CELL_LOAD
   } cell_op_type;

endpackage

@@ rtl/core/sqe_if.sv @@
// Valid and ready channels for command and result transactions of the engine.
// Depends on sqe_pkg for the field widths.
`timescale 1ns / 1ps

interface sqe_req_if;
   logic                              valid;
   logic                              ready;
   logic [sqe_pkg::CMD_W-1:0]         command;
   logic signed [sqe_pkg::DATA_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);
endinterface

interface sqe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sqe_pkg::DATA_W-1:0]   data;
   logic [sqe_pkg::STATUS_W-1:0]        status;
   logic                                last;

   modport source (output valid, output data, output status, output last, input ready);
   modport sink (input valid, input data, input status, input last, output ready);
endinterface

@@ rtl/core/sqe_cell.sv @@
// One storage cell of the element chain: holds one value and takes its next
// value from itself, a neighbor, the front cell or the pushed value. Uses sqe_pkg.
`timescale 1ns / 1ps

module sqe_cell (
   input  logic                              clock,
   input  sqe_pkg::cell_op_type              op,
   input  logic signed [sqe_pkg::DATA_W-1:0] left_data,
   input  logic signed [sqe_pkg::DATA_W-1:0] right_data,
   input  logic signed [sqe_pkg::DATA_W-1:0] front_data,
   input  logic signed [sqe_pkg::DATA_W-1:0] load_data,
   output logic signed [sqe_pkg::DATA_W-1:0] data_ff
);

   logic signed [sqe_pkg::DATA_W-1:0] data_in;

   always_comb begin
      unique case (op)
         sqe_pkg::CELL_TAKE_LEFT:  data_in = left_data;
         sqe_pkg::CELL_TAKE_RIGHT: data_in = right_data;
         sqe_pkg::CELL_TAKE_FRONT: data_in = front_data;
         sqe_pkg::CELL_LOAD:       data_in = load_data;
         default:                  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ rtl/core/stack_queue_engine_unit.sv @@
// Stack and queue engine: a row of cells with the front element in cell zero.
// Push, pop, swap and peek give one result, registered in the cycle after acceptance;
// such commands are taken every cycle while results are consumed.
// Dump of n elements gives n results, one per cycle while results are consumed, by
// rotating the occupied cells; no command is accepted during the dump.
// Synchronous reset clears the state, count, mode and output valid; cells are not reset.
`timescale 1ns / 1ps
`include "stack_queue_engine_unit_assert.svh"

module stack_queue_engine_unit #(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   sqe_req_if.sink   req_bus,
   sqe_rsp_if.source rsp_bus,
   input  logic      csr_write_enable,
   input  logic      csr_write_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type                         state_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  dump_left_ff;
   logic                              queue_mode_ff;
   logic                              rsp_valid_ff;
   logic signed [sqe_pkg::DATA_W-1:0] rsp_data_ff;
   sqe_pkg::status_type               rsp_status_ff;
   logic                              rsp_last_ff;

   logic signed [sqe_pkg::DATA_W-1:0] cell_data [DEPTH];
   sqe_pkg::cell_op_type              cell_op [DEPTH];

   sqe_pkg::cmd_type cmd;
   logic             slot_free;
   logic             accept;
   logic             dump_step;
   logic             is_full;
   logic             is_empty;
   logic             has_two;
   logic             push_full_acc;
   logic             pop_ok_acc;

   assign cmd       = sqe_pkg::cmd_type'(req_bus.command);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_bus.valid && req_bus.ready;
   assign dump_step = (state_ff == ST_DUMP) && slot_free;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign has_two   = (count_ff >= CNT_W'(2));
   assign push_full_acc = accept && (cmd == sqe_pkg::CMD_PUSH) && is_full;
   assign pop_ok_acc    = accept && (cmd == sqe_pkg::CMD_POP) && !is_empty;

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.data   = rsp_data_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.last   = rsp_last_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_op[i] = sqe_pkg::CELL_HOLD;
         if (accept) begin
            case (cmd)
               sqe_pkg::CMD_PUSH: begin
                  if (!is_full) begin
                     if (!queue_mode_ff) begin
                        cell_op[i] = (i == 0) ? sqe_pkg::CELL_LOAD : sqe_pkg::CELL_TAKE_LEFT;
                     end else if (CNT_W'(i) == count_ff) begin
                        cell_op[i] = sqe_pkg::CELL_LOAD;
                     end
                  end
               end
               sqe_pkg::CMD_POP: begin
                  if (!is_empty) begin
                     cell_op[i] = sqe_pkg::CELL_TAKE_RIGHT;
                  end
               end
               sqe_pkg::CMD_SWAP: begin
                  if (has_two) begin
                     if (i == 0) begin
                        cell_op[i] = sqe_pkg::CELL_TAKE_RIGHT;
                     end else if (i == 1) begin
                        cell_op[i] = sqe_pkg::CELL_TAKE_LEFT;
                     end
                  end
               end
               default: cell_op[i] = sqe_pkg::CELL_HOLD;
            endcase
         end else if (dump_step) begin
            if (CNT_W'(i + 1) < count_ff) begin
               cell_op[i] = sqe_pkg::CELL_TAKE_RIGHT;
            end else if (CNT_W'(i + 1) == count_ff) begin
               cell_op[i] = sqe_pkg::CELL_TAKE_FRONT;
            end
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      sqe_cell u_cell (
         .clock      (clock),
         .op         (cell_op[g]),
         .left_data  (cell_data[(g == 0) ? 0 : g - 1]),
         .right_data (cell_data[(g == DEPTH - 1) ? DEPTH - 1 : g + 1]),
         .front_data (cell_data[0]),
         .load_data  (req_bus.value),
         .data_ff    (cell_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         dump_left_ff  <= '0;
         queue_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            queue_mode_ff <= csr_write_data;
         end
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_data_ff   <= '0;
                  rsp_status_ff <= sqe_pkg::STATUS_OK;
                  rsp_last_ff   <= 1'b1;
                  unique case (cmd)
                     sqe_pkg::CMD_PUSH: begin
                        rsp_valid_ff <= 1'b1;
                        if (is_full) begin
                           rsp_status_ff <= sqe_pkg::STATUS_FULL;
                        end else begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     sqe_pkg::CMD_POP: begin
                        rsp_valid_ff <= 1'b1;
                        if (is_empty) begin
                           rsp_status_ff <= sqe_pkg::STATUS_EMPTY;
                        end else begin
                           rsp_data_ff <= cell_data[0];
                           count_ff    <= count_ff - 1'b1;
                        end
                     end
                     sqe_pkg::CMD_SWAP: begin
                        rsp_valid_ff <= 1'b1;
                        if (!has_two) begin
                           rsp_status_ff <= sqe_pkg::STATUS_SHORT;
                        end
                     end
                     sqe_pkg::CMD_PEEK: begin
                        rsp_valid_ff <= 1'b1;
                        if (is_empty) begin
                           rsp_status_ff <= sqe_pkg::STATUS_EMPTY;
                        end else begin
                           rsp_data_ff <= cell_data[0];
                        end
                     end
                     sqe_pkg::CMD_DUMP: begin
                        if (is_empty) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= sqe_pkg::STATUS_EMPTY;
                        end else begin
                           state_ff     <= ST_DUMP;
                           dump_left_ff <= count_ff;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= rsp_valid_ff && !rsp_bus.ready;
                     end
                  endcase
               end
            end
            ST_DUMP: begin
               if (dump_step) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= cell_data[0];
                  rsp_status_ff <= sqe_pkg::STATUS_OK;
                  rsp_last_ff   <= (dump_left_ff == CNT_W'(1));
                  dump_left_ff  <= dump_left_ff - 1'b1;
                  if (dump_left_ff == CNT_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `SQE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `SQE_ASSERT_IMPLIES(a_no_accept_in_dump, clock, reset, state_ff == ST_DUMP, !req_bus.ready)
   `SQE_ASSERT_IMPLIES(a_dump_left_live, clock, reset, state_ff == ST_DUMP, dump_left_ff != '0)
   `SQE_ASSERT_NEXT(a_full_push_keeps, clock, reset, push_full_acc, count_ff == $past(count_ff))
   `SQE_ASSERT_NEXT(a_pop_drops_one, clock, reset, pop_ok_acc, count_ff == $past(count_ff) - 1'b1)

endmodule
